// ----- rtl/stable_priority_queue_core_defines.svh -----
// Assertion helpers for the stable priority queue core.
// Each macro expects i_clk and i_rst_n in the enclosing module.
`ifndef STABLE_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("spq: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("spq: next-cycle check failed");

`endif

// ----- rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes of the stable priority queue core.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    // Command function codes
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // Job queue between front and back; depth must be a power of two
    localparam int unsigned JQ_DEPTH = 2;
    localparam int unsigned JQ_AW    = $clog2(JQ_DEPTH);
    localparam int unsigned JQ_CW    = $clog2(JQ_DEPTH + 1);

    typedef struct packed {
        logic       func;
        logic [3:0] priority_req;
        logic [7:0] tag;
    } t_cmd;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] out_priority;
        logic [7:0] out_tag;
        logic [3:0] occupancy;
    } t_rsp;

    // Job kinds decided by the front
    typedef enum logic [1:0] {
        OP_INSERT,
        OP_REMOVE,
        OP_FULL,
        OP_EMPTY
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [3:0] pri;
        logic [7:0] tag;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_push;

    // One stored queue entry
    typedef struct packed {
        logic [3:0] slot_priority;
        logic [7:0] slot_tag;
    } t_slot;

endpackage

`default_nettype wire

// ----- rtl/stable_priority_queue_core.sv -----
// ----------------------------------------------------------------------------
// stable_priority_queue_core
// Bounded priority queue, lower priority number first, equal priorities in
// arrival order. Push drops and reports when full; pop reports when empty.
// ----------------------------------------------------------------------------
//
// Channel    Ports                      Transfer
// ---------  -------------------------  ---------------------------------
// command    start, busy, i_cmd         edge with start high, busy low
// result     o_done, o_rsp              every edge with o_done high
//
// Steps: a pop reads the head slot, then reports; full and empty jobs report
// from idle; a push shifts each held entry with a larger priority back (the
// slot memory moves one entry per cycle through its single write port).
// Commands queue in a two-deep job queue; busy rises only when it is full.
// Reset: synchronous, active low; clears counts and pointers, no slot sweep.
// The result strobe lasts one cycle and the receiver cannot stall it.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_priority_queue_core #(
    parameter int unsigned BUFFER_COUNT = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire spq_pkg::t_cmd i_cmd,
    output logic               o_done,
    output spq_pkg::t_rsp      o_rsp
);
    import spq_pkg::*;

    // Queue holds two entries per buffer
    localparam int unsigned CAP = 2 * BUFFER_COUNT;

    t_job_push push;
    logic      jq_full;
    logic      jq_valid;
    t_job      jq_job;
    logic      jq_take;

    // Hold off commands only while the job queue is full
    assign busy = jq_full;

    // Classify each transfer: insert, remove, or report full / empty
    spq_front #(
        .CAP(CAP)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_full (jq_full),
        .i_cmd  (i_cmd),
        .o_push (push)
    );

    // Decouple acceptance from execution
    spq_job_fifo u_jq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_full (jq_full),
        .o_valid(jq_valid),
        .o_job  (jq_job),
        .i_take (jq_take)
    );

    // Carry out the job on the slot memory and drive the result register
    spq_back #(
        .CAP(CAP)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(jq_valid),
        .i_job  (jq_job),
        .o_take (jq_take),
        .o_done (o_done),
        .o_rsp  (o_rsp)
    );

endmodule

`default_nettype wire

// ----- rtl/spq_job_fifo.sv -----
// ----------------------------------------------------------------------------
// spq_job_fifo
// Short job queue that decouples the front classifier from the back sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stable_priority_queue_core_defines.svh"

module spq_job_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire spq_pkg::t_job_push i_push,
    output logic                   o_full,
    output logic                   o_valid,
    output spq_pkg::t_job          o_job,
    input  wire logic              i_take
);
    import spq_pkg::*;

    t_job             r_mem [JQ_DEPTH];
    logic [JQ_AW-1:0] r_wp;
    logic [JQ_AW-1:0] r_rp;
    logic [JQ_CW-1:0] r_cnt;
    logic [JQ_AW-1:0] n_wp;
    logic [JQ_AW-1:0] n_rp;
    logic [JQ_CW-1:0] n_cnt;
    logic             wr;
    logic             rd;

    assign o_full  = (r_cnt == JQ_CW'(JQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];

    assign wr = i_push.valid && !o_full;
    assign rd = i_take && o_valid;

    always_comb begin
        n_wp  = wr ? r_wp + JQ_AW'(1) : r_wp;
        n_rp  = rd ? r_rp + JQ_AW'(1) : r_rp;
        n_cnt = r_cnt;
        if (wr && !rd) begin
            n_cnt = r_cnt + JQ_CW'(1);
        end else if (rd && !wr) begin
            n_cnt = r_cnt - JQ_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_push.job;
        end
    end

    `SPQ_ASSERT_SAME(a_fifo_no_overflow, i_push.valid, !o_full)
    `SPQ_ASSERT_SAME(a_fifo_no_underflow, i_take, o_valid)

endmodule

`default_nettype wire

// ----- rtl/spq_front.sv -----
// ----------------------------------------------------------------------------
// spq_front
// Accepts commands and classifies them against a shadow entry count.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_front #(
    parameter int unsigned CAP = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_full,
    input  wire spq_pkg::t_cmd i_cmd,
    output spq_pkg::t_job_push o_push
);
    import spq_pkg::*;

    localparam int unsigned CW = $clog2(CAP + 1);

    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          accept;

    assign accept = i_start && !i_full;

    always_comb begin
        o_push.valid   = accept;
        o_push.job.pri = i_cmd.priority_req;
        o_push.job.tag = i_cmd.tag;
        o_push.job.op  = OP_EMPTY;
        n_cnt          = r_cnt;
        if (i_cmd.func == FUNC_PUSH) begin
            if (r_cnt == CW'(CAP)) begin
                o_push.job.op = OP_FULL;
            end else begin
                o_push.job.op = OP_INSERT;
                n_cnt         = r_cnt + CW'(1);
            end
        end else begin
            if (r_cnt == '0) begin
                o_push.job.op = OP_EMPTY;
            end else begin
                o_push.job.op = OP_REMOVE;
                n_cnt         = r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (accept) begin
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/spq_back.sv -----
// ----------------------------------------------------------------------------
// spq_back
// Executes queued jobs on a circular slot memory and issues the results.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stable_priority_queue_core_defines.svh"

module spq_back #(
    parameter int unsigned CAP = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire spq_pkg::t_job i_job,
    output logic               o_take,
    output logic               o_done,
    output spq_pkg::t_rsp      o_rsp
);
    import spq_pkg::*;

    localparam int unsigned AW = $clog2(CAP);
    localparam int unsigned CW = $clog2(CAP + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_PLACE,
        S_POP
    } t_state;

    t_state        r_state;
    t_state        n_state;
    logic [AW-1:0] r_head;
    logic [AW-1:0] n_head;
    logic [AW-1:0] r_tail;
    logic [AW-1:0] n_tail;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [AW-1:0] r_k;
    logic [AW-1:0] n_k;
    logic [AW-1:0] r_rd;
    logic [AW-1:0] n_rd;
    logic [CW-1:0] r_rem;
    logic [CW-1:0] n_rem;
    t_slot         r_new;
    t_slot         n_new;
    logic          r_done;
    logic          n_done;
    t_rsp          r_rsp;
    t_rsp          n_rsp;

    t_slot         r_mem [CAP];
    t_slot         r_rd_data;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_slot         mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    function automatic logic [AW-1:0] prv(input logic [AW-1:0] p);
        return (p == '0) ? AW'(CAP - 1) : p - AW'(1);
    endfunction

    function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
        return (p == AW'(CAP - 1)) ? '0 : p + AW'(1);
    endfunction

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_k       = r_k;
        n_rd      = r_rd;
        n_rem     = r_rem;
        n_new     = r_new;
        n_done    = 1'b0;
        n_rsp     = r_rsp;
        mem_we    = 1'b0;
        mem_waddr = r_k;
        mem_wdata = r_new;
        mem_re    = 1'b0;
        mem_raddr = r_rd;
        o_take    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_take              = 1'b1;
                    n_new.slot_priority = i_job.pri;
                    n_new.slot_tag      = i_job.tag;
                    n_rsp.out_priority  = '0;
                    n_rsp.out_tag       = '0;
                    n_rsp.occupancy     = 4'(r_count);
                    case (i_job.op)
                        OP_FULL: begin
                            n_done       = 1'b1;
                            n_rsp.status = STATUS_FULL;
                        end
                        OP_EMPTY: begin
                            n_done       = 1'b1;
                            n_rsp.status = STATUS_EMPTY;
                        end
                        OP_INSERT: begin
                            // walk back from the tail, moving larger priorities down
                            n_count = r_count + CW'(1);
                            n_tail  = nxt(r_tail);
                            n_k     = r_tail;
                            n_rd    = prv(r_tail);
                            n_rem   = r_count;
                            if (r_count == '0) begin
                                n_state = S_PLACE;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = prv(r_tail);
                                n_state   = S_SCAN;
                            end
                        end
                        OP_REMOVE: begin
                            mem_re    = 1'b1;
                            mem_raddr = r_head;
                            n_state   = S_POP;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_rd_data.slot_priority > r_new.slot_priority) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_k;
                    mem_wdata = r_rd_data;
                    n_k       = r_rd;
                    n_rd      = prv(r_rd);
                    n_rem     = r_rem - CW'(1);
                    if (r_rem == CW'(1)) begin
                        n_state = S_PLACE;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = prv(r_rd);
                    end
                end else begin
                    mem_we          = 1'b1;
                    n_done          = 1'b1;
                    n_rsp.status    = STATUS_OK;
                    n_rsp.occupancy = 4'(r_count);
                    n_state         = S_IDLE;
                end
            end
            S_PLACE: begin
                mem_we          = 1'b1;
                n_done          = 1'b1;
                n_rsp.status    = STATUS_OK;
                n_rsp.occupancy = 4'(r_count);
                n_state         = S_IDLE;
            end
            S_POP: begin
                n_done             = 1'b1;
                n_rsp.status       = STATUS_OK;
                n_rsp.out_priority = r_rd_data.slot_priority;
                n_rsp.out_tag      = r_rd_data.slot_tag;
                n_rsp.occupancy    = 4'(r_count - CW'(1));
                n_count            = r_count - CW'(1);
                n_head             = nxt(r_head);
                n_state            = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_done  <= n_done;
        end
        r_k   <= n_k;
        r_rd  <= n_rd;
        r_rem <= n_rem;
        r_new <= n_new;
        r_rsp <= n_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    `SPQ_ASSERT_SAME(a_count_bound, 1'b1, r_count <= CW'(CAP))
    `SPQ_ASSERT_SAME(a_scan_has_work, r_state == S_SCAN, r_rem != '0)
    `SPQ_ASSERT_NEXT(a_pop_reports, r_state == S_POP, r_done)
    `SPQ_ASSERT_SAME(a_no_write_idle, mem_we, r_state != S_IDLE)

endmodule

`default_nettype wire
